// ----- hdl/tpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared constants and types for the triangle point containment core.
// ----------------------------------------------------------------------------
package tpc_pkg;

   localparam int COORD_WIDTH_DEF   = 16;
   localparam int FRACTION_BITS_DEF = 8;
   localparam int FIELD_W           = 16;
   localparam int NUM_FIELDS        = 12;
   localparam int REQ_TDATA_W       = FIELD_W * NUM_FIELDS;
   localparam int RSP_TDATA_W       = 8;
   localparam int TOL_W             = 8;

   typedef struct packed {
      logic degenerate;
      logic on_edge;
      logic inside_res;
   } rsp_flags_type;

endpackage
`default_nettype wire

// ----- hdl/tpc_cross_sq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_cross_sq
// Pipelined squared length of the cross product u x v, five stages.
// ----------------------------------------------------------------------------
module tpc_cross_sq #(
   parameter int DW = 17
) (
   input  wire logic                        clock,
   input  wire logic                        adv,
   input  wire logic [2:0][DW-1:0]          u_in,
   input  wire logic [2:0][DW-1:0]          v_in,
   output logic      [2*(2*DW-1)+1:0]       sq_out
);
   localparam int XW   = 2 * DW;
   localparam int MW   = 2 * DW - 1;
   localparam int H    = (MW + 1) / 2;
   localparam int HI_W = MW - H;
   localparam int SQ2  = 2 * MW;
   localparam int SQ_W = 2 * MW + 2;

   logic signed [XW-1:0]    comp_ff [3];
   logic [MW-1:0]           mag_ff  [3];
   logic [2*HI_W-1:0]       hh_ff   [3];
   logic [HI_W+H-1:0]       hl_ff   [3];
   logic [2*H-1:0]          ll_ff   [3];
   logic [SQ2-1:0]          sq_ff   [3];
   logic [SQ_W-1:0]         sum_ff;

   genvar k;
   generate
      for (k = 0; k < 3; k++) begin : g_comp
         logic signed [XW-1:0] p1, p2;
         logic [HI_W-1:0]      hi;
         logic [H-1:0]         lo;
         assign p1 = $signed(u_in[(k+1)%3]) * $signed(v_in[(k+2)%3]);
         assign p2 = $signed(u_in[(k+2)%3]) * $signed(v_in[(k+1)%3]);
         assign hi = mag_ff[k][MW-1:H];
         assign lo = mag_ff[k][H-1:0];
         always_ff @(posedge clock) begin
            if (adv) begin
               comp_ff[k] <= p1 - p2;
               mag_ff[k]  <= comp_ff[k][XW-1] ? MW'(-comp_ff[k]) : MW'(comp_ff[k]);
               hh_ff[k]   <= hi * hi;
               hl_ff[k]   <= hi * lo;
               ll_ff[k]   <= lo * lo;
               sq_ff[k]   <= (SQ2'(hh_ff[k]) << (2 * H)) + (SQ2'(hl_ff[k]) << (H + 1))
                             + SQ2'(ll_ff[k]);
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]);
      end
   end

   assign sq_out = sum_ff;

endmodule
`default_nettype wire

// ----- hdl/tpc_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tpc_isqrt #(
   parameter int RAD_W = 84
) (
   input  wire logic                 clock,
   input  wire logic                 adv,
   input  wire logic [RAD_W-1:0]     rad_in,
   output logic      [RAD_W/2-1:0]   root_out
);
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 1;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];

   genvar g;
   generate
      for (g = 0; g < ROOT_W; g++) begin : g_stage
         logic [REM_W-1:0]  rem_prev;
         logic [ROOT_W-1:0] root_prev;
         logic [RAD_W-1:0]  rad_prev;
         logic [REM_W+1:0]  trial, test, diff;
         logic              ge;
         if (g == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad_in;
         end else begin : g_next
            assign rem_prev  = rem_ff[g-1];
            assign root_prev = root_ff[g-1];
            assign rad_prev  = rad_ff[g-1];
         end
         // bring down two radicand bits, try (4*root + 1)
         assign trial = {rem_prev, rad_prev[RAD_W-1 -: 2]};
         assign test  = {1'b0, root_prev, 2'b01};
         assign ge    = trial >= test;
         assign diff  = trial - test;
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[g]  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
               root_ff[g] <= {root_prev[ROOT_W-2:0], ge};
               rad_ff[g]  <= rad_prev << 2;
            end
         end
      end
   endgenerate

   assign root_out = root_ff[ROOT_W-1];

endmodule
`default_nettype wire

// ----- hdl/tpc_ratio.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_ratio
// Pipelined fixed-point ratio num/den, one quotient bit per stage, saturating
// to one plus one unit when num exceeds den.
// ----------------------------------------------------------------------------
module tpc_ratio #(
   parameter int VAL_W     = 42,
   parameter int FRAC_BITS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   adv,
   input  wire logic [VAL_W-1:0]       num_in,
   input  wire logic [VAL_W-1:0]       den_in,
   output logic      [FRAC_BITS+1:0]   ratio_out
);
   localparam int Q_W = FRAC_BITS + 2;
   localparam int NS  = FRAC_BITS + 1;
   localparam logic [Q_W-1:0] SAT_VAL = (Q_W'(1) << FRAC_BITS) + Q_W'(1);

   logic [VAL_W-1:0] rem_ff [NS];
   logic [VAL_W-1:0] den_ff [NS];
   logic [Q_W-1:0]   q_ff   [NS];
   logic             sat_ff [NS];

   genvar g;
   generate
      for (g = 0; g < NS; g++) begin : g_stage
         logic [VAL_W:0]   rem_cur, diff;
         logic [VAL_W-1:0] den_cur;
         logic [Q_W-1:0]   q_prev;
         logic             sat_cur, ge;
         if (g == 0) begin : g_first
            assign rem_cur = {1'b0, num_in};
            assign den_cur = den_in;
            assign q_prev  = '0;
            assign sat_cur = num_in > den_in;
         end else begin : g_next
            assign rem_cur = {rem_ff[g-1], 1'b0};
            assign den_cur = den_ff[g-1];
            assign q_prev  = q_ff[g-1];
            assign sat_cur = sat_ff[g-1];
         end
         assign ge   = rem_cur >= {1'b0, den_cur};
         assign diff = rem_cur - {1'b0, den_cur};
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[g] <= ge ? diff[VAL_W-1:0] : rem_cur[VAL_W-1:0];
               den_ff[g] <= den_cur;
               q_ff[g]   <= {q_prev[Q_W-2:0], ge};
               sat_ff[g] <= sat_cur;
            end
         end
      end
   endgenerate

   assign ratio_out = sat_ff[NS-1] ? SAT_VAL : q_ff[NS-1];

endmodule
`default_nettype wire

// ----- hdl/triangle_point_containment_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_point_containment_core
// Point-in-triangle test for 3D integer triangles using area ratios.
// ----------------------------------------------------------------------------
// Pipeline depth is set mainly by the one-bit-per-stage square root.
// Throughput: one transaction per cycle; a stall on rsp freezes the whole pipe.
// Reset clears the valid bits, the output valid register and edge_tolerance.
// ----------------------------------------------------------------------------
module triangle_point_containment_core #(
   parameter int COORD_WIDTH   = tpc_pkg::COORD_WIDTH_DEF,
   parameter int FRACTION_BITS = tpc_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [tpc_pkg::TOL_W-1:0]         csr_wr_data,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // vertex_a_x,y,z, vertex_b_x,y,z, vertex_c_x,y,z, query_x,y,z; 16 bits each
   input  wire logic [tpc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // inside_res, on_edge, degenerate, zero fill
   output logic [tpc_pkg::RSP_TDATA_W-1:0]        rsp_tdata
);
   import tpc_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int FB    = FRACTION_BITS;
   localparam int DW    = CW + 1;
   localparam int MW    = 2 * DW - 1;
   localparam int SQ_W  = 2 * MW + 2;
   localparam int RAD_W = SQ_W + 2 * FB;
   localparam int RW    = RAD_W / 2;
   localparam int Q_W   = FB + 2;
   localparam int C_W   = (FB + 4 > 10) ? FB + 4 : 10;
   localparam int VLD_N = 6 + RW + FB + 1;
   localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FB;
   localparam logic [C_W-1:0] ONE_C = C_W'(1) << FB;

   logic                 adv;
   logic [TOL_W-1:0]     tol_ff;
   logic [VLD_N-1:0]     vld_ff;
   logic [FB:0]          deg_ff;
   logic                 rsp_tvalid_ff;
   rsp_flags_type        flags_ff, flags_in;

   logic signed [DW-1:0] pa_pt [4][3];
   logic [2:0][DW-1:0]   ab_ff, ac_ff, pa_ff, pb_ff, pc_ff;
   logic [SQ_W-1:0]      sq_d, sq_a, sq_b;
   logic [RW-1:0]        md, mxa, mxb;
   logic [Q_W-1:0]       ra, rb;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // point index 0..3 = A, B, C, query
   genvar p, d;
   generate
      for (p = 0; p < 4; p++) begin : g_pt
         for (d = 0; d < 3; d++) begin : g_dim
            logic [CW-1:0] raw;
            assign raw        = CW'(req_tdata[(3*p+d)*FIELD_W +: FIELD_W]);
            assign pa_pt[p][d] = DW'($signed(raw));
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            ab_ff[i] <= pa_pt[1][i] - pa_pt[0][i];
            ac_ff[i] <= pa_pt[2][i] - pa_pt[0][i];
            pa_ff[i] <= pa_pt[0][i] - pa_pt[3][i];
            pb_ff[i] <= pa_pt[1][i] - pa_pt[3][i];
            pc_ff[i] <= pa_pt[2][i] - pa_pt[3][i];
         end
      end
   end

   tpc_cross_sq #(.DW(DW)) u_cross_d (
      .clock(clock), .adv(adv), .u_in(ab_ff), .v_in(ac_ff), .sq_out(sq_d));
   tpc_cross_sq #(.DW(DW)) u_cross_a (
      .clock(clock), .adv(adv), .u_in(pb_ff), .v_in(pc_ff), .sq_out(sq_a));
   tpc_cross_sq #(.DW(DW)) u_cross_b (
      .clock(clock), .adv(adv), .u_in(pc_ff), .v_in(pa_ff), .sq_out(sq_b));

   tpc_isqrt #(.RAD_W(RAD_W)) u_sqrt_d (
      .clock(clock), .adv(adv), .rad_in(RAD_W'(sq_d) << (2 * FB)), .root_out(md));
   tpc_isqrt #(.RAD_W(RAD_W)) u_sqrt_a (
      .clock(clock), .adv(adv), .rad_in(RAD_W'(sq_a) << (2 * FB)), .root_out(mxa));
   tpc_isqrt #(.RAD_W(RAD_W)) u_sqrt_b (
      .clock(clock), .adv(adv), .rad_in(RAD_W'(sq_b) << (2 * FB)), .root_out(mxb));

   tpc_ratio #(.VAL_W(RW), .FRAC_BITS(FB)) u_ratio_a (
      .clock(clock), .adv(adv), .num_in(mxa), .den_in(md), .ratio_out(ra));
   tpc_ratio #(.VAL_W(RW), .FRAC_BITS(FB)) u_ratio_b (
      .clock(clock), .adv(adv), .num_in(mxb), .den_in(md), .ratio_out(rb));

   // zero area shows as a zero root; carried alongside the divider
   always_ff @(posedge clock) begin
      if (adv) begin
         deg_ff <= (FB+1)'({deg_ff, md == '0});
      end
   end

   logic [C_W-1:0] rc, tol_s, tol_n;
   logic           ain, bin, cin;
   assign rc    = ONE_C - C_W'(ra) - C_W'(rb);
   assign tol_s = C_W'(tol_ff);
   assign tol_n = -tol_s;
   assign ain   = ra <= ONE_Q;
   assign bin   = rb <= ONE_Q;
   assign cin   = !rc[C_W-1] && (rc <= ONE_C);

   always_comb begin
      flags_in            = '0;
      flags_in.degenerate = deg_ff[FB];
      if (!deg_ff[FB]) begin
         flags_in.inside_res = ain && bin && cin;
         flags_in.on_edge    = ain && bin &&
            ((cin && (ra == '0 || rb == '0)) ||
             ($signed(rc) <= $signed(tol_s) && $signed(rc) >= $signed(tol_n)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
         tol_ff        <= '0;
      end else begin
         if (csr_wr_en) tol_ff <= csr_wr_data;
         if (adv) begin
            vld_ff        <= {vld_ff[VLD_N-2:0], req_tvalid};
            rsp_tvalid_ff <= vld_ff[VLD_N-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) flags_ff <= flags_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({flags_ff.degenerate, flags_ff.on_edge,
                                     flags_ff.inside_res});

   a_deg_clears_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && flags_ff.degenerate |-> !flags_ff.inside_res && !flags_ff.on_edge)
      else $error("degenerate result carries inside or edge flag");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during a stall");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid_ff && vld_ff == '0)
      else $error("pipeline not empty after reset");

endmodule
`default_nettype wire
